>>> hdl/fcfl_pkg.sv
// Shared types and codes for the fixed-chunk free-list pool.
`default_nettype none

package fcfl_pkg;

   // Request operations.
   localparam logic [1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [1:0] FUNC_FREE    = 2'd1;
   localparam logic [1:0] FUNC_CLEAR   = 2'd2;
   localparam logic [1:0] FUNC_DESTROY = 2'd3;

   // Result status codes.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_INVALID = 2'd1;
   localparam logic [1:0] STAT_UNINIT  = 2'd2;
   localparam logic [1:0] STAT_EMPTY   = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CHUNK_BYTES = 2'd0;
   localparam logic [1:0] CSR_ALIGN_LOG2  = 2'd1;
   localparam logic [1:0] CSR_CHUNK_COUNT = 2'd2;

   // Field widths.
   localparam int FUNC_W        = 2;
   localparam int INDEX_W       = 8;
   localparam int STAT_W        = 2;
   localparam int OFFSET_W      = 24;
   localparam int CHUNK_BYTES_W = 16;
   localparam int ALIGN_W       = 4;
   localparam int COUNT_W       = 9;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int STRIDE_W      = 17;
   localparam int RSP_FIELDS_W  = STAT_W + INDEX_W + OFFSET_W;
   localparam int RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Configuration reset values.
   localparam logic [CHUNK_BYTES_W-1:0] CHUNK_BYTES_RST = 16'd8;
   localparam logic [ALIGN_W-1:0]       ALIGN_LOG2_RST  = 4'd3;
   localparam logic [COUNT_W-1:0]       CHUNK_COUNT_RST = 9'd256;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              push;
      logic              alloc_read;
      logic              alloc_done;
      logic              clear_start;
      logic              clear_step;
      logic              destroy;
      logic              load_rsp;
      logic [STAT_W-1:0] rsp_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic head_null;
      logic idx_invalid;
      logic pool_ready;
      logic clear_last;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> hdl/fcfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fcfl_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256
) (
   input  wire                     clock,
   input  wire                     we,
   input  wire [$clog2(DEPTH)-1:0] waddr,
   input  wire [WIDTH-1:0]         wdata,
   input  wire                     re,
   input  wire [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

>>> hdl/fcfl_ctrl.sv
// Controller state machine for the chunk pool: handshakes and command sequencing.
`default_nettype none

module fcfl_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire [fcfl_pkg::FUNC_W-1:0]   req_func,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   input  wire fcfl_pkg::dp_stat_type   stat,
   output fcfl_pkg::cmd_type            cmd
);

   import fcfl_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ALLOC = 2'd1;
   localparam logic [1:0] S_CLEAR = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       clr_uninit_ff, clr_uninit_in;
   logic       slot_free;
   logic       accept;

   // The output slot is free when empty or being drained at this edge.
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      clr_uninit_in = clr_uninit_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_ALLOC: begin
                     if (stat.head_null) begin
                        cmd.load_rsp   = 1'b1;
                        cmd.rsp_status = STAT_EMPTY;
                     end else begin
                        cmd.alloc_read = 1'b1;
                        state_in       = S_ALLOC;
                     end
                  end
                  FUNC_FREE: begin
                     cmd.load_rsp = 1'b1;
                     if (stat.idx_invalid) begin
                        cmd.rsp_status = STAT_INVALID;
                     end else if (!stat.pool_ready) begin
                        cmd.rsp_status = STAT_UNINIT;
                     end else begin
                        cmd.push       = 1'b1;
                        cmd.rsp_status = STAT_OK;
                     end
                  end
                  FUNC_CLEAR: begin
                     cmd.clear_start = 1'b1;
                     clr_uninit_in   = !stat.pool_ready;
                     state_in        = S_CLEAR;
                  end
                  default: begin
                     cmd.destroy    = 1'b1;
                     cmd.load_rsp   = 1'b1;
                     cmd.rsp_status = stat.pool_ready ? STAT_OK : STAT_UNINIT;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            // The link read issued at the transfer has landed.
            cmd.alloc_done = 1'b1;
            cmd.load_rsp   = 1'b1;
            cmd.rsp_status = STAT_OK;
            state_in       = S_IDLE;
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_status = clr_uninit_ff ? STAT_UNINIT : STAT_OK;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         clr_uninit_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         clr_uninit_ff <= clr_uninit_in;
      end
   end

   // A waiting result is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !cmd.load_rsp)
      else $error("result overwritten while stalled");

   // An allocate leaves S_ALLOC for idle with its result registered in the output slot.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC) |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("allocate did not complete in one cycle");

   // A clear always ends with a result in the output slot.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && stat.clear_last) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("clear finished without a result");

endmodule

`default_nettype wire

>>> hdl/fcfl_dp.sv
// Datapath for the chunk pool: configuration, free-list head, link memory and result.
`default_nettype none

module fcfl_dp #(
   parameter int MAX_CHUNKS    = 256,
   parameter int POINTER_BYTES = 8
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire fcfl_pkg::cmd_type             cmd,
   output fcfl_pkg::dp_stat_type              stat,
   input  wire                                csr_we,
   input  wire [fcfl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire [fcfl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire [fcfl_pkg::INDEX_W-1:0]        req_index,
   output logic [fcfl_pkg::STAT_W-1:0]        rsp_status,
   output logic [fcfl_pkg::INDEX_W-1:0]       rsp_granted,
   output logic [fcfl_pkg::OFFSET_W-1:0]      rsp_offset
);

   import fcfl_pkg::*;

   localparam int IDX_W  = $clog2(MAX_CHUNKS);
   localparam int LINK_W = IDX_W + 1;
   localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
   localparam int CW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_CHUNKS);

   logic [CHUNK_BYTES_W-1:0] chunk_bytes_ff;
   logic [ALIGN_W-1:0]       align_log2_ff;
   logic [COUNT_W-1:0]       chunk_count_ff;
   logic [STRIDE_W-1:0]      stride_ff, stride_in;
   logic [LINK_W-1:0]        head_ff, head_in;
   logic                     ready_ff, ready_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [STAT_W-1:0]        rsp_status_ff;
   logic [INDEX_W-1:0]       rsp_granted_ff;
   logic [OFFSET_W-1:0]      rsp_offset_ff;

   logic [CW-1:0]            pool_size;
   logic [CW-1:0]            idx_ext;
   logic [CHUNK_BYTES_W-1:0] min_size;
   logic [STRIDE_W-1:0]      align_mask;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic [LINK_W-1:0]        mem_wdata;
   logic [LINK_W-1:0]        mem_rdata;

   // Pool size follows the live count: zero acts as one, large counts clamp.
   always_comb begin
      pool_size = CW'(chunk_count_ff);
      if (pool_size == '0) begin
         pool_size = CW'(1);
      end
      if (pool_size > CW'(MAX_CHUNKS)) begin
         pool_size = CW'(MAX_CHUNKS);
      end
   end

   assign idx_ext = CW'(req_index);

   // Stride is the chunk size raised to a pointer and rounded up to the alignment.
   always_comb begin
      min_size = chunk_bytes_ff;
      if (min_size < CHUNK_BYTES_W'(POINTER_BYTES)) begin
         min_size = CHUNK_BYTES_W'(POINTER_BYTES);
      end
      align_mask = (STRIDE_W'(1) << align_log2_ff) - STRIDE_W'(1);
      stride_in  = (STRIDE_W'(min_size) + align_mask) & ~align_mask;
   end

   assign stat.head_null   = (head_ff == LINK_NULL);
   assign stat.idx_invalid = (idx_ext >= pool_size);
   assign stat.pool_ready  = ready_ff;
   assign stat.clear_last  = (cnt_ff == pool_size - CW'(1));

   // Link memory writes: a push links the old head, a clear step links the next chunk (null at the last).
   always_comb begin
      mem_we    = cmd.push || cmd.clear_step;
      mem_waddr = cmd.push ? idx_ext[IDX_W-1:0] : cnt_ff[IDX_W-1:0];
      if (cmd.push) begin
         mem_wdata = head_ff;
      end else if (stat.clear_last) begin
         mem_wdata = LINK_NULL;
      end else begin
         mem_wdata = LINK_W'(cnt_ff) + LINK_W'(1);
      end
   end

   fcfl_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_CHUNKS)
   ) u_link_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (cmd.alloc_read),
      .raddr (head_ff[IDX_W-1:0]),
      .rdata (mem_rdata)
   );

   always_comb begin
      head_in  = head_ff;
      ready_in = ready_ff;
      cnt_in   = cnt_ff;
      if (cmd.push) begin
         head_in = LINK_W'(idx_ext[IDX_W-1:0]);
      end else if (cmd.alloc_done) begin
         head_in = mem_rdata;
      end else if (cmd.destroy) begin
         head_in  = LINK_NULL;
         ready_in = 1'b0;
      end else if (cmd.clear_start) begin
         cnt_in = '0;
      end else if (cmd.clear_step) begin
         cnt_in = cnt_ff + CW'(1);
         if (stat.clear_last) begin
            head_in  = '0;
            ready_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_bytes_ff <= CHUNK_BYTES_RST;
         align_log2_ff  <= ALIGN_LOG2_RST;
         chunk_count_ff <= CHUNK_COUNT_RST;
         head_ff        <= LINK_NULL;
         ready_ff       <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CHUNK_BYTES: chunk_bytes_ff <= csr_wdata;
               CSR_ALIGN_LOG2:  align_log2_ff  <= csr_wdata[ALIGN_W-1:0];
               CSR_CHUNK_COUNT: chunk_count_ff <= csr_wdata[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         head_ff  <= head_in;
         ready_ff <= ready_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Result payload and the precomputed stride need no reset.
   always_ff @(posedge clock) begin
      stride_ff <= stride_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.rsp_status;
         if (cmd.alloc_done) begin
            rsp_granted_ff <= INDEX_W'(head_ff[IDX_W-1:0]);
            // The product is formed at full offset width and keeps its low bits.
            rsp_offset_ff  <= OFFSET_W'(head_ff[IDX_W-1:0]) * OFFSET_W'(stride_ff);
         end else begin
            rsp_granted_ff <= '0;
            rsp_offset_ff  <= '0;
         end
      end
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_offset  = rsp_offset_ff;

   // The head holds a chunk number or the null marker, nothing else.
   assert property (@(posedge clock) disable iff (reset)
      head_ff <= LINK_NULL)
      else $error("free-list head out of range");

   // A push makes the freed chunk the new head.
   assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> head_ff == LINK_W'($past(idx_ext[IDX_W-1:0])))
      else $error("push did not update head");

   // The last clear step leaves a ready pool headed by chunk zero.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.clear_step && stat.clear_last) |=> ready_ff && head_ff == '0)
      else $error("clear did not leave the pool ready");

endmodule

`default_nettype wire

>>> hdl/fixed_chunk_free_list_pool.sv
// Free, destroy and allocate from an empty pool give a result the cycle after the
// transfer; allocate with a free chunk reads link memory first, then loads the result.
// Clear sweeps the link memory one entry a cycle, then loads its result.
// Free and destroy take one request per cycle while results drain; allocate with a
// free chunk holds off the next request during the registered link-memory read.
// Reset clears control state: pool not ready, list empty; the link memory is not cleared.
`default_nettype none

module fixed_chunk_free_list_pool #(
   parameter int MAX_CHUNKS    = 256,
   parameter int POINTER_BYTES = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [fcfl_pkg::INDEX_W-1:0]         req_tdata,   // chunk_index
   input  wire [fcfl_pkg::FUNC_W-1:0]          req_tuser,   // func
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // status, granted_index, byte_offset, zero fill
   output logic [fcfl_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  wire                                 csr_we,
   input  wire [fcfl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [fcfl_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import fcfl_pkg::*;

   cmd_type                cmd;
   dp_stat_type            stat;
   logic [STAT_W-1:0]      rsp_status;
   logic [INDEX_W-1:0]     rsp_granted;
   logic [OFFSET_W-1:0]    rsp_offset;

   fcfl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fcfl_dp #(
      .MAX_CHUNKS    (MAX_CHUNKS),
      .POINTER_BYTES (POINTER_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_index   (req_tdata),
      .rsp_status  (rsp_status),
      .rsp_granted (rsp_granted),
      .rsp_offset  (rsp_offset)
   );

   assign rsp_tdata = {(RSP_TDATA_W - RSP_FIELDS_W)'(0), rsp_offset, rsp_granted, rsp_status};

endmodule

`default_nettype wire
